### sv/nqe_pkg.sv
package nqe_pkg;

    localparam int MAX_SIZE_DEF = 16;
    localparam int CFG_W        = 5;
    localparam int COL_W        = 4;
    localparam int PLACE_W      = 64;
    localparam logic [CFG_W-1:0] CFG_RESET = 5'd8;

    typedef enum logic [1:0] {
        S_IDLE,
        S_STEP,
        S_BACK,
        S_SCAN
    } t_state;

    typedef struct packed {
        logic             we;
        logic [COL_W-1:0] data;
    } t_stk_wr;

endpackage

### sv/nqe_stack.sv
module nqe_stack #(
    parameter int MAX_SIZE = nqe_pkg::MAX_SIZE_DEF,
    parameter int CNT_W    = $clog2(MAX_SIZE + 1),
    parameter int IDX_W    = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1
) (
    input  logic                        i_clk,
    input  nqe_pkg::t_stk_wr            i_wr,
    input  logic [IDX_W-1:0]            i_waddr,
    input  logic [IDX_W-1:0]            i_raddr,
    input  logic [CNT_W-1:0]            i_n,
    output logic [nqe_pkg::COL_W-1:0]   o_rdata,
    output logic [nqe_pkg::PLACE_W-1:0] o_placement
);

    logic [nqe_pkg::COL_W-1:0] r_mem [MAX_SIZE];

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem[i_waddr] <= i_wr.data;
        end
    end

    assign o_rdata = r_mem[i_raddr];

    // rows at or above the board size read as zero
    always_comb begin
        o_placement = '0;
        for (int r = 0; r < MAX_SIZE; r++) begin
            if (CNT_W'(r) < i_n) begin
                o_placement[nqe_pkg::COL_W*r +: nqe_pkg::COL_W] = r_mem[r];
            end
        end
    end

endmodule

### sv/nqe_conflict.sv
module nqe_conflict #(
    parameter int CNT_W = 5
) (
    input  logic [nqe_pkg::COL_W-1:0] i_col,
    input  logic [CNT_W-1:0]          i_cand,
    input  logic [CNT_W-1:0]          i_row,
    input  logic [CNT_W-1:0]          i_prev_row,
    output logic                      o_conflict
);

    logic [CNT_W-1:0] col_ext;
    logic [CNT_W-1:0] dc;
    logic [CNT_W-1:0] dr;

    assign col_ext = CNT_W'(i_col);
    assign dc      = (col_ext > i_cand) ? (col_ext - i_cand) : (i_cand - col_ext);
    assign dr      = i_row - i_prev_row;

    // same column, or same diagonal in either direction
    assign o_conflict = (col_ext == i_cand) || (dc == dr);

endmodule

### sv/nqe_seq.sv
module nqe_seq #(
    parameter int MAX_SIZE = nqe_pkg::MAX_SIZE_DEF,
    parameter int CNT_W    = $clog2(MAX_SIZE + 1),
    parameter int IDX_W    = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic                        i_restart,
    input  logic [nqe_pkg::CFG_W-1:0]   i_board_size,
    input  logic [nqe_pkg::COL_W-1:0]   i_rdata,
    input  logic [nqe_pkg::PLACE_W-1:0] i_placement,
    input  logic                        i_conflict,
    output logic                        o_busy,
    output nqe_pkg::t_stk_wr            o_wr,
    output logic [IDX_W-1:0]            o_waddr,
    output logic [IDX_W-1:0]            o_raddr,
    output logic [CNT_W-1:0]            o_n,
    output logic [CNT_W-1:0]            o_cand,
    output logic [CNT_W-1:0]            o_row,
    output logic [CNT_W-1:0]            o_prev_row,
    output logic                        o_valid,
    output logic                        o_found,
    output logic [nqe_pkg::PLACE_W-1:0] o_placement
);

    nqe_pkg::t_state r_state, n_state;

    logic [CNT_W-1:0]            r_n, n_n;
    logic [CNT_W-1:0]            r_d, n_d;
    logic [CNT_W-1:0]            r_c, n_c;
    logic [CNT_W-1:0]            r_k, n_k;
    logic [CNT_W-1:0]            r_depth, n_depth;
    logic                        r_started, n_started;
    logic                        r_exhausted, n_exhausted;
    logic                        r_valid, n_valid;
    logic                        r_found, n_found;
    logic [nqe_pkg::PLACE_W-1:0] r_placement, n_placement;

    logic [CNT_W-1:0] n_sat;
    logic [CNT_W-1:0] d_sat;
    logic             accept;
    logic             fresh;

    assign o_busy = (r_state != nqe_pkg::S_IDLE);
    assign accept = i_start && !o_busy;
    assign fresh  = i_restart || !r_started;

    assign n_sat = (i_board_size > nqe_pkg::CFG_W'(MAX_SIZE)) ? CNT_W'(MAX_SIZE)
                                                             : CNT_W'(i_board_size);
    assign d_sat = (r_depth > n_sat) ? n_sat : r_depth;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            nqe_pkg::S_IDLE: begin
                if (accept) begin
                    if (fresh) begin
                        n_state = nqe_pkg::S_STEP;
                    end else if (!r_exhausted && d_sat != '0) begin
                        n_state = nqe_pkg::S_BACK;
                    end
                end
            end
            nqe_pkg::S_STEP: begin
                if (r_d >= r_n) begin
                    n_state = nqe_pkg::S_IDLE;
                end else if (r_c >= r_n) begin
                    n_state = (r_d == '0) ? nqe_pkg::S_IDLE : nqe_pkg::S_BACK;
                end else begin
                    n_state = nqe_pkg::S_SCAN;
                end
            end
            nqe_pkg::S_BACK: begin
                n_state = nqe_pkg::S_STEP;
            end
            nqe_pkg::S_SCAN: begin
                if (r_k == r_d || i_conflict) begin
                    n_state = nqe_pkg::S_STEP;
                end
            end
            default: n_state = nqe_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        n_n         = r_n;
        n_d         = r_d;
        n_c         = r_c;
        n_k         = r_k;
        n_depth     = r_depth;
        n_started   = r_started;
        n_exhausted = r_exhausted;
        n_valid     = 1'b0;
        n_found     = r_found;
        n_placement = r_placement;
        o_wr.we     = 1'b0;
        o_wr.data   = nqe_pkg::COL_W'(r_c);
        unique case (r_state)
            nqe_pkg::S_IDLE: begin
                if (accept) begin
                    n_n = n_sat;
                    if (fresh) begin
                        n_started   = 1'b1;
                        n_exhausted = 1'b0;
                        n_d         = '0;
                        n_c         = '0;
                    end else if (r_exhausted) begin
                        n_valid     = 1'b1;
                        n_found     = 1'b0;
                        n_placement = '0;
                    end else if (d_sat == '0) begin
                        n_exhausted = 1'b1;
                        n_valid     = 1'b1;
                        n_found     = 1'b0;
                        n_placement = '0;
                    end else begin
                        n_d = d_sat - CNT_W'(1);
                    end
                end
            end
            nqe_pkg::S_STEP: begin
                if (r_d >= r_n) begin
                    n_depth     = r_d;
                    n_valid     = 1'b1;
                    n_found     = 1'b1;
                    n_placement = i_placement;
                end else if (r_c >= r_n) begin
                    if (r_d == '0) begin
                        n_exhausted = 1'b1;
                        n_depth     = '0;
                        n_valid     = 1'b1;
                        n_found     = 1'b0;
                        n_placement = '0;
                    end else begin
                        n_d = r_d - CNT_W'(1);
                    end
                end else begin
                    n_k = '0;
                end
            end
            nqe_pkg::S_BACK: begin
                // resume one column past the saved one
                n_c = CNT_W'(i_rdata) + CNT_W'(1);
            end
            nqe_pkg::S_SCAN: begin
                if (r_k == r_d) begin
                    o_wr.we = 1'b1;
                    n_d     = r_d + CNT_W'(1);
                    n_c     = '0;
                end else if (i_conflict) begin
                    n_c = r_c + CNT_W'(1);
                end else begin
                    n_k = r_k + CNT_W'(1);
                end
            end
            default: ;
        endcase
    end

    assign o_waddr    = r_d[IDX_W-1:0];
    assign o_raddr    = (r_state == nqe_pkg::S_BACK) ? r_d[IDX_W-1:0] : r_k[IDX_W-1:0];
    assign o_n        = r_n;
    assign o_cand     = r_c;
    assign o_row      = r_d;
    assign o_prev_row = r_k;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= nqe_pkg::S_IDLE;
            r_depth     <= '0;
            r_started   <= 1'b0;
            r_exhausted <= 1'b0;
            r_valid     <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_depth     <= n_depth;
            r_started   <= n_started;
            r_exhausted <= n_exhausted;
            r_valid     <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n         <= n_n;
        r_d         <= n_d;
        r_c         <= n_c;
        r_k         <= n_k;
        r_found     <= n_found;
        r_placement <= n_placement;
    end

    assign o_valid     = r_valid;
    assign o_found     = r_found;
    assign o_placement = r_placement;

endmodule

### sv/n_queens_solution_enumerator.sv
// N-queens solution enumerator.
// Set the board size with i_cfg_we / i_cfg_data (range 1..MAX_SIZE, larger values
// saturate) while the block is idle. Issue a request by raising start while busy is
// low; i_restart = 1 begins a new search, 0 continues after the last solution.
// Each request yields one transaction: o_valid is high for exactly one cycle with
// o_found and o_placement (4-bit column per row, row r in bits 4r+3..4r).
// The search runs on one shared conflict comparator under a small sequencer. Each
// candidate square passes a step state and is compared against each placed row in
// turn; a candidate with no conflict is then placed. Each backtrack passes a back
// state, which reads the saved column, and then a step state. The time to a result
// is therefore data dependent. busy stays high until the result is produced; the
// result is registered and appears in the cycle after the final decision.
// A new request may be issued in the same cycle the result is shown.
// Reset returns the board size to 8 and forgets any search in progress, so the next
// request starts from an empty board. The receiver cannot stall the block.
module n_queens_solution_enumerator #(
    parameter int MAX_SIZE = nqe_pkg::MAX_SIZE_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        i_restart,
    input  logic                        i_cfg_we,
    input  logic [nqe_pkg::CFG_W-1:0]   i_cfg_data,
    output logic                        o_valid,
    output logic                        o_found,
    output logic [nqe_pkg::PLACE_W-1:0] o_placement
);

    localparam int CNT_W = $clog2(MAX_SIZE + 1);
    localparam int IDX_W = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;

    logic [nqe_pkg::CFG_W-1:0]   r_board_size;
    nqe_pkg::t_stk_wr            stk_wr;
    logic [IDX_W-1:0]            stk_waddr;
    logic [IDX_W-1:0]            stk_raddr;
    logic [CNT_W-1:0]            size_n;
    logic [nqe_pkg::COL_W-1:0]   stk_rdata;
    logic [nqe_pkg::PLACE_W-1:0] stk_placement;
    logic [CNT_W-1:0]            cand;
    logic [CNT_W-1:0]            row;
    logic [CNT_W-1:0]            prev_row;
    logic                        conflict;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_board_size <= nqe_pkg::CFG_RESET;
        end else if (i_cfg_we) begin
            r_board_size <= i_cfg_data;
        end
    end

    nqe_seq #(
        .MAX_SIZE (MAX_SIZE),
        .CNT_W    (CNT_W),
        .IDX_W    (IDX_W)
    ) u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_restart    (i_restart),
        .i_board_size (r_board_size),
        .i_rdata      (stk_rdata),
        .i_placement  (stk_placement),
        .i_conflict   (conflict),
        .o_busy       (busy),
        .o_wr         (stk_wr),
        .o_waddr      (stk_waddr),
        .o_raddr      (stk_raddr),
        .o_n          (size_n),
        .o_cand       (cand),
        .o_row        (row),
        .o_prev_row   (prev_row),
        .o_valid      (o_valid),
        .o_found      (o_found),
        .o_placement  (o_placement)
    );

    nqe_stack #(
        .MAX_SIZE (MAX_SIZE),
        .CNT_W    (CNT_W),
        .IDX_W    (IDX_W)
    ) u_stack (
        .i_clk       (i_clk),
        .i_wr        (stk_wr),
        .i_waddr     (stk_waddr),
        .i_raddr     (stk_raddr),
        .i_n         (size_n),
        .o_rdata     (stk_rdata),
        .o_placement (stk_placement)
    );

    nqe_conflict #(
        .CNT_W (CNT_W)
    ) u_conflict (
        .i_col      (stk_rdata),
        .i_cand     (cand),
        .i_row      (row),
        .i_prev_row (prev_row),
        .o_conflict (conflict)
    );

endmodule
